>>> sv/integer_packing_decoder_defines.svh
// Assertion macros for the verification files of the decoder.
`ifndef INTEGER_PACKING_DECODER_DEFINES_SVH
`define INTEGER_PACKING_DECODER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define IPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define IPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define IPD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ipd_pkg.sv
package ipd_pkg;

    // Field and register widths.
    localparam int ELEM_W      = 16;
    localparam int SUM_W       = 32;
    localparam int BYTES_W     = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ELEMENT_BYTES = 2'd0,
        CFG_UNSIGNED_MODE = 2'd1
    } t_cfg_index;

    // Element width code that selects 16-bit elements; every other code selects 8 bits.
    localparam logic [BYTES_W-1:0] BYTES_WIDE        = 2'd2;
    localparam logic [BYTES_W-1:0] BYTES_RESET_VALUE = 2'd1;

    // Limit values of the element widths.
    localparam logic [7:0]  BYTE_UMAX = 8'hFF;
    localparam logic [7:0]  BYTE_SMAX = 8'h7F;
    localparam logic [7:0]  BYTE_SMIN = 8'h80;
    localparam logic [15:0] HALF_UMAX = 16'hFFFF;
    localparam logic [15:0] HALF_SMAX = 16'h7FFF;
    localparam logic [15:0] HALF_SMIN = 16'h8000;

    // Bounds of the running sum.
    localparam logic [SUM_W-1:0] SUM_MAX = 32'h7FFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_MIN = 32'h8000_0000;

    // Current configuration.
    typedef struct packed {
        logic [BYTES_W-1:0] element_bytes;
        logic               unsigned_mode;
    } t_cfg;

    // One input beat as held in the input register.
    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic              last;
    } t_elem_beat;

endpackage

>>> sv/integer_packing_decoder.sv
// A beat that closes a run goes from the input register into the result register.
// Throughput: one input beat per cycle; the combinational add and clamp on the running
// sum allow that rate. Input stalls only while a result waits in the output register.
// Reset (synchronous, active low) empties both registers, clears the running sum and
// its saturation flag, and sets element_bytes to 1 and unsigned_mode to 0.
module integer_packing_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ipd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [ipd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Element stream in.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [15:0]                      s_axis_tdata,  // [15:0] packed_element
    input  logic                             s_axis_tlast,  // last_element
    // Decoded value stream out.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // [31:0] decoded_value
    output logic [0:0]                       m_axis_tuser   // [0] saturated
);
    import ipd_pkg::*;

    t_cfg       cfg;
    t_elem_beat in_beat;
    t_elem_beat held_beat;
    logic       held_valid;
    logic       take;

    assign o_cfg_ready = 1'b1;

    ipd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign in_beat.elem = s_axis_tdata;
    assign in_beat.last = s_axis_tlast;

    ipd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_beat  (in_beat),
        .o_ready (s_axis_tready),
        .i_take  (take),
        .o_valid (held_valid),
        .o_beat  (held_beat)
    );

    ipd_accum u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (held_valid),
        .i_beat      (held_beat),
        .o_take      (take),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_value     (m_axis_tdata),
        .o_sat       (m_axis_tuser[0])
    );

endmodule

>>> sv/ipd_cfg_regs.sv
module ipd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [ipd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [ipd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output ipd_pkg::t_cfg                    o_cfg
);
    import ipd_pkg::*;

    t_cfg r_cfg;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.element_bytes <= BYTES_RESET_VALUE;
            r_cfg.unsigned_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ELEMENT_BYTES: r_cfg.element_bytes <= i_cfg_data[BYTES_W-1:0];
                CFG_UNSIGNED_MODE: r_cfg.unsigned_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/ipd_in_stage.sv
module ipd_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ipd_pkg::t_elem_beat i_beat,
    output logic                o_ready,
    input  logic                i_take,
    output logic                o_valid,
    output ipd_pkg::t_elem_beat o_beat
);
    import ipd_pkg::*;

    logic       r_valid;
    t_elem_beat r_beat;
    logic       load;

    // The register takes a new beat when empty or when its beat moves on.
    assign o_ready = !r_valid || i_take;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

>>> sv/ipd_accum.sv
module ipd_accum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ipd_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    input  ipd_pkg::t_elem_beat         i_beat,
    output logic                        o_take,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ipd_pkg::SUM_W-1:0]   o_value,
    output logic                        o_sat
);
    import ipd_pkg::*;

    logic                  wide;
    logic                  uns;
    logic [7:0]            elem_lo;
    logic signed [ELEM_W:0] elem_val;
    logic                  is_limit;
    logic [SUM_W:0]        sum_ext;
    logic                  overflow;
    logic [SUM_W-1:0]      n_sum;
    logic                  n_sat;
    logic                  emit;
    logic                  out_free;

    logic [SUM_W-1:0]      r_sum;
    logic                  r_sat;
    logic                  r_out_valid;
    logic [SUM_W-1:0]      r_out_value;
    logic                  r_out_sat;

    assign wide    = (i_cfg.element_bytes == BYTES_WIDE);
    assign uns     = i_cfg.unsigned_mode;
    assign elem_lo = i_beat.elem[7:0];

    // Element value and limit detection for the selected width and signedness.
    always_comb begin
        if (wide) begin
            elem_val = uns ? {1'b0, i_beat.elem} : {i_beat.elem[ELEM_W-1], i_beat.elem};
            is_limit = uns ? (i_beat.elem == HALF_UMAX)
                           : (i_beat.elem == HALF_SMAX || i_beat.elem == HALF_SMIN);
        end else begin
            elem_val = uns ? {9'd0, elem_lo} : {{9{elem_lo[7]}}, elem_lo};
            is_limit = uns ? (elem_lo == BYTE_UMAX)
                           : (elem_lo == BYTE_SMAX || elem_lo == BYTE_SMIN);
        end
    end

    // One-bit-wider add, then clamp to the signed 32-bit bounds.
    assign sum_ext  = {r_sum[SUM_W-1], r_sum}
                    + {{(SUM_W-ELEM_W){elem_val[ELEM_W]}}, elem_val};
    assign overflow = sum_ext[SUM_W] ^ sum_ext[SUM_W-1];
    assign n_sum    = overflow ? (sum_ext[SUM_W] ? SUM_MIN : SUM_MAX) : sum_ext[SUM_W-1:0];
    assign n_sat    = r_sat || overflow;

    // A limit element not marked last keeps the run open and needs no output slot.
    assign emit     = !is_limit || i_beat.last;
    assign out_free = !r_out_valid || i_out_ready;
    assign o_take   = i_valid && (out_free || !emit);

    // Running sum and its saturation flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_sat <= 1'b0;
        end else if (o_take) begin
            if (emit) begin
                r_sum <= '0;
                r_sat <= 1'b0;
            end else begin
                r_sum <= n_sum;
                r_sat <= n_sat;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_out_value <= n_sum;
            r_out_sat   <= n_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_sat       = r_out_sat;

endmodule

>>> sv/ipd_checker.sv
`include "integer_packing_decoder_defines.svh"

module ipd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser
);

    logic in_beat;
    logic out_stall;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // A stalled result keeps its value and flag.
    `IPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // The input side only stalls behind a result that is waiting.
    `IPD_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, out_stall, "input stalled without a waiting result")

    // A result that appears in an empty output comes from a beat accepted on the input,
    // which passed through the input register into the result register.
    `IPD_ASSERT_IMPL(a_out_origin, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(in_beat, 2), "result without a matching input beat")

    // Reset leaves no result on the output.
    `IPD_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid, "result valid after reset")

endmodule

bind integer_packing_decoder ipd_checker u_ipd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/sv/integer_packing_decoder_tb.sv
`timescale 1ns / 100ps

module integer_packing_decoder_tb;
    import ipd_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int IDLE_SETTLE    = 4;
    localparam int END_SETTLE     = 8;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int RANDOM_PHASES  = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int TIMEOUT_NS     = 4_000_000;

    // Register indexes that hold no register; writes to them must do nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam longint RUN_SUM_HI = longint'($signed(SUM_MAX));
    localparam longint RUN_SUM_LO = longint'($signed(SUM_MIN));

    typedef struct {
        logic [SUM_W-1:0] value;
        logic             sat;
    } t_decoded;

    // Tracks the decoder's registers and running sum, and holds the decoded
    // values still to come out of the block.
    class decode_scoreboard;
        logic [BYTES_W-1:0] bytes_code;
        logic               uns_code;
        longint             run_sum;
        bit                 run_sat;
        t_decoded           decoded_q[$];
        int                 mismatches;

        function new();
            bytes_code = BYTES_RESET_VALUE;
            uns_code   = 1'b0;
            run_sum    = 0;
            run_sat    = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_ELEMENT_BYTES: bytes_code = data;
                CFG_UNSIGNED_MODE: uns_code = data[0];
                default: ;
            endcase
        endfunction

        // Adds one accepted element to the run and queues the value it closes, if any.
        function void note_element(logic [ELEM_W-1:0] raw, logic last);
            longint   elem;
            bit       limit;
            t_decoded item;
            if (bytes_code == BYTES_WIDE) begin
                elem  = uns_code ? longint'(raw) : longint'($signed(raw));
                limit = uns_code ? (raw == HALF_UMAX)
                                 : (raw == HALF_SMAX || raw == HALF_SMIN);
            end else begin
                elem  = uns_code ? longint'(raw[7:0]) : longint'($signed(raw[7:0]));
                limit = uns_code ? (raw[7:0] == BYTE_UMAX)
                                 : (raw[7:0] == BYTE_SMAX || raw[7:0] == BYTE_SMIN);
            end
            run_sum = run_sum + elem;
            if (run_sum > RUN_SUM_HI) begin
                run_sum = RUN_SUM_HI;
                run_sat = 1'b1;
            end else if (run_sum < RUN_SUM_LO) begin
                run_sum = RUN_SUM_LO;
                run_sat = 1'b1;
            end
            if (limit && !last)
                return;
            item.value = run_sum[SUM_W-1:0];
            item.sat   = run_sat;
            decoded_q  = {decoded_q, item};
            run_sum = 0;
            run_sat = 1'b0;
        endfunction

        // Compares one output beat with the oldest queued value.
        function void check_value(logic [SUM_W-1:0] value, logic sat);
            t_decoded want;
            if (decoded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected output beat: value %0d saturated %0b",
                             $signed(value), sat);
                return;
            end
            want = decoded_q.pop_front();
            if (value !== want.value || sat !== want.sat) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("output mismatch: value expected %0d got %0d, saturated expected %0b got %0b",
                             $signed(want.value), $signed(value), want.sat, sat);
            end
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [15:0]            s_axis_tdata;  // [15:0] packed_element
    logic                   s_axis_tlast;  // last_element
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [31:0]            m_axis_tdata;  // [31:0] decoded_value
    logic [0:0]             m_axis_tuser;  // [0] saturated

    decode_scoreboard sb = new();

    // Configuration the stimulus generator assumes, to pick limit elements.
    bit cur_wide;
    bit cur_uns;
    int burst_left;
    int rx_cycle;
    int rx_mode;

    integer_packing_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watch all three channels; every handshake is sampled at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_element(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_value(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // Output backpressure: the mode is redrawn at random, periodically, among always
    // ready, coin-flip ready, mostly stalled and a repeating pattern of long stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_cycle      <= 0;
            rx_mode       <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 97 == 0)
                rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (rx_cycle % 32) >= 20;
            endcase
        end
    end

    // Holds one element beat until the block takes it.
    task automatic put_beat(input logic [15:0] elem, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= elem;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Sends one element within the burst pattern, opening a new burst with a
    // random gap when the current one runs out.
    task automatic send_beat(input logic [15:0] elem, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        put_beat(elem, last);
    endtask

    // Stops sending until every queued value has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Lets a trailing limit beat clear the pipeline before registers change.
    task automatic wait_idle();
        drain();
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // Writes both registers back to back, optionally followed by a write to
    // an unused index that the block must ignore.
    task automatic write_regs(input logic [CFG_DATA_W-1:0] bytes_code,
                              input logic [CFG_DATA_W-1:0] mode_code,
                              input bit                    spare);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ELEMENT_BYTES;
        i_cfg_data  <= bytes_code;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_UNSIGNED_MODE;
        i_cfg_data  <= mode_code;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (spare) begin
            i_cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI;
            i_cfg_data  <= CFG_DATA_W'($urandom);
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cur_wide = (bytes_code == BYTES_WIDE);
        cur_uns  = mode_code[0];
    endtask

    // A limit element for the current setting; the ignored upper byte is random.
    function automatic logic [15:0] pick_limit();
        if (cur_wide) begin
            if (cur_uns)
                return HALF_UMAX;
            return $urandom_range(0, 1) ? HALF_SMAX : HALF_SMIN;
        end
        if (cur_uns)
            return {8'($urandom), BYTE_UMAX};
        return {8'($urandom), ($urandom_range(0, 1) ? BYTE_SMAX : BYTE_SMIN)};
    endfunction

    // Mostly runs of limit elements closed by a random element, with some
    // plain noise and the odd early last flag.
    task automatic random_phase(input int n_items);
        int sent = 0;
        int run_len;
        while (sent < n_items) begin
            if ($urandom_range(0, 299) == 0)
                drain();
            if ($urandom_range(0, 4) != 0) begin
                run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 40)
                                                       : $urandom_range(0, 5);
                repeat (run_len) begin
                    send_beat(pick_limit(), $urandom_range(0, 24) == 0);
                    sent++;
                end
                send_beat(16'($urandom), $urandom_range(0, 7) == 0);
                sent++;
            end else begin
                send_beat(16'($urandom), $urandom_range(0, 15) == 0);
                sent++;
            end
        end
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_ELEMENT_BYTES;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        cur_wide   = 1'b0;
        cur_uns    = 1'b0;
        burst_left = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: signed bytes. Both limits sum, the upper byte is
        // ignored, and a limit marked last closes the run at once.
        send_beat(16'h007F, 1'b0);
        send_beat(16'h0080, 1'b0);
        send_beat(16'h0005, 1'b0);
        send_beat(16'hFF00, 1'b0);
        send_beat(16'hAB7F, 1'b1);
        send_beat(16'h00FF, 1'b0);

        // Unsigned 16-bit: zero is not a limit, only the maximum is.
        wait_idle();
        write_regs(BYTES_WIDE, 2'd1, 1'b0);
        send_beat(HALF_UMAX, 1'b0);
        send_beat(HALF_UMAX, 1'b0);
        send_beat(16'h0000, 1'b0);
        send_beat(HALF_UMAX, 1'b1);
        send_beat(HALF_SMIN, 1'b0);

        // Width code 3 still means bytes; unsigned byte limit.
        wait_idle();
        write_regs(2'd3, 2'd1, 1'b1);
        send_beat(16'h12FF, 1'b0);
        send_beat(16'h0080, 1'b0);
        send_beat(16'h0000, 1'b0);

        // Width code 0 means bytes; only bit 0 of the mode counts.
        wait_idle();
        write_regs(2'd0, 2'd2, 1'b1);
        send_beat(16'h0080, 1'b0);
        send_beat(16'h1234, 1'b0);

        // Signed 16-bit limits on both sides.
        wait_idle();
        write_regs(BYTES_WIDE, 2'd0, 1'b0);
        send_beat(HALF_SMAX, 1'b0);
        send_beat(HALF_SMIN, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(HALF_SMAX, 1'b1);

        // A width and mode change in the middle of a run keeps the running
        // sum, and later elements add to it under the new setting.
        wait_idle();
        write_regs(BYTES_WIDE, 2'd0, 1'b0);
        repeat (3) put_beat(HALF_SMIN, 1'b0);
        wait_idle();
        write_regs(2'd1, 2'd1, 1'b0);
        put_beat(16'h00FF, 1'b0);
        put_beat(16'h0001, 1'b0);

        // Random traffic over every width code and both modes.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            write_regs(2'(p), {1'($urandom_range(0, 1)), 1'(p / 4)},
                       1'($urandom_range(0, 1)));
            random_phase(RANDOM_ITEMS / RANDOM_PHASES);
        end

        drain();
        repeat (END_SETTLE) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            if (sb.pending() > 0)
                $display("%0d decoded values never came out", sb.pending());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
